/* design/stp_pkg.sv */
package stp_pkg;

  // Input item kinds.
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_UP    = 2'd1,
    FUNC_DOWN  = 2'd2,
    FUNC_COAST = 2'd3
  } func_e;

  localparam logic [15:0] SprReset = 16'd200;
  localparam logic [3:0]  CoilsOff = 4'h0;

  // Sequencer state carried from one item to the next.
  typedef struct packed {
    logic [1:0]  phase_index;
    logic [15:0] steps_left;
    logic [19:0] delay_left;
    logic [19:0] hold_value;
    logic        phase_up;
    logic [3:0]  coil_state;
    logic [15:0] step_position;
  } state_t;

  // Result of one item, as stored in the output register.
  typedef struct packed {
    logic [3:0]  coils;
    logic        busy_res;
    logic [15:0] position;
    logic        rejected;
  } result_t;

  // Full-step coil patterns: bit0 A1, bit1 A2, bit2 B1, bit3 B2.
  function automatic logic [3:0] phase_pattern(input logic [1:0] idx);
    logic [3:0] pat;
    case (idx)
      2'd0:    pat = 4'h5;
      2'd1:    pat = 4'h6;
      2'd2:    pat = 4'hA;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

/* design/stp_if.sv */
interface stp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] step_count;
  logic [19:0] hold_ticks;

  modport source(output valid, output func, output step_count, output hold_ticks,
                 input ready);
  modport sink(input valid, input func, input step_count, input hold_ticks,
               output ready);
endinterface

interface stp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  coils;
  logic        busy_res;
  logic [15:0] position;
  logic        rejected;

  modport source(output valid, output coils, output busy_res, output position,
                 output rejected, input ready);
  modport sink(input valid, input coils, input busy_res, input position,
               input rejected, output ready);
endinterface

/* design/stp_step.sv */
module stp_step (
  input  stp_pkg::state_t state_i,
  input  logic [1:0]      func_i,
  input  logic [15:0]     step_count_i,
  input  logic [19:0]     hold_ticks_i,
  input  logic [15:0]     steps_per_rev_i,
  output stp_pkg::state_t state_o,
  output logic            rejected_o
);

  logic        busy;
  logic        do_step;
  logic        step_dir_up;
  logic [19:0] delay_dec;
  logic [1:0]  step_phase;
  logic [16:0] pos_inc;
  logic        pos_wrap;
  logic [15:0] step_pos;

  assign busy      = (state_i.steps_left != '0) || (state_i.delay_left != '0);
  assign delay_dec = (state_i.delay_left != '0) ? state_i.delay_left - 20'd1
                                                : state_i.delay_left;

  // A new move sets the direction before its first step is taken.
  assign step_dir_up = (func_i == stp_pkg::FUNC_TICK) ? state_i.phase_up
                                                      : (func_i == stp_pkg::FUNC_UP);
  assign step_phase  = step_dir_up ? state_i.phase_index + 2'd1
                                   : state_i.phase_index - 2'd1;

  // A zero register means the counter wraps at its natural width.
  assign pos_inc  = {1'b0, state_i.step_position} + 17'd1;
  assign pos_wrap = (steps_per_rev_i == '0) ? pos_inc[16]
                                            : (pos_inc >= {1'b0, steps_per_rev_i});
  assign step_pos = pos_wrap ? '0 : pos_inc[15:0];

  always_comb begin
    state_o    = state_i;
    rejected_o = 1'b0;
    do_step    = 1'b0;
    unique case (func_i)
      stp_pkg::FUNC_TICK: begin
        state_o.delay_left = delay_dec;
        if ((delay_dec == '0) && (state_i.steps_left != '0)) begin
          do_step            = 1'b1;
          state_o.steps_left = state_i.steps_left - 16'd1;
          state_o.delay_left = state_i.hold_value;
        end
      end
      stp_pkg::FUNC_COAST: begin
        if (busy) begin
          rejected_o = 1'b1;
        end else begin
          state_o.coil_state = stp_pkg::CoilsOff;
          state_o.steps_left = '0;
          state_o.delay_left = hold_ticks_i;
        end
      end
      default: begin
        if (busy) begin
          rejected_o = 1'b1;
        end else if (step_count_i != '0) begin
          do_step            = 1'b1;
          state_o.phase_up   = step_dir_up;
          state_o.hold_value = hold_ticks_i;
          state_o.steps_left = step_count_i - 16'd1;
          state_o.delay_left = hold_ticks_i;
        end
      end
    endcase
    if (do_step) begin
      state_o.phase_index   = step_phase;
      state_o.coil_state    = stp_pkg::phase_pattern(step_phase);
      state_o.step_position = step_pos;
    end
  end

endmodule

/* design/stepper_full_step_sequencer.sv */
// The result of an item is registered and shown in the cycle after its transfer is taken.
// Throughput: one item per cycle; the state update for an item is a single pass
// through the step logic between the state registers and the result register.
// A new item is taken whenever the result register is empty or being read.
// Reset (rst_ni low, asynchronous): motion stops, coils are off, position is
// zero, steps_per_rev returns to 200 and no result is pending.
module stepper_full_step_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  stp_in_if.sink      in_ch,
  stp_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  // Configuration register: modulus of the position counter.
  logic [15:0] steps_per_rev_q;

  // Sequencer state, advanced once for each accepted input transfer.
  stp_pkg::state_t state_q, state_d;
  logic            rejected_d;

  // Output register. Its valid flag is the only handshake state needed:
  // the input side stalls only while a result waits and is not being taken.
  logic             out_valid_q;
  stp_pkg::result_t result_q, result_d;
  logic             in_fire;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_per_rev_q <= stp_pkg::SprReset;
    end else if (cfg_we_i) begin
      steps_per_rev_q <= cfg_wdata_i;
    end
  end

  // Next-state logic for one item: tick countdown, command decode, step.
  stp_step u_step (
    .state_i        (state_q),
    .func_i         (in_ch.func),
    .step_count_i   (in_ch.step_count),
    .hold_ticks_i   (in_ch.hold_ticks),
    .steps_per_rev_i(steps_per_rev_q),
    .state_o        (state_d),
    .rejected_o     (rejected_d)
  );

  always_comb begin
    result_d.coils    = state_d.coil_state;
    result_d.busy_res = (state_d.steps_left != '0) || (state_d.delay_left != '0);
    result_d.position = state_d.step_position;
    result_d.rejected = rejected_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      // A new result replaces the old one in the same cycle the old one leaves.
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.coils    = result_q.coils;
  assign out_ch.busy_res = result_q.busy_res;
  assign out_ch.position = result_q.position;
  assign out_ch.rejected = result_q.rejected;

endmodule

/* design/stp_checker.sv */
module stp_assertions (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_busy_res_i,
  input logic out_rejected_i
);

  // A pending result stays until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // Every accepted item produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item produced no result");

  // With nothing pending, the input side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // A command is only refused while motion or a hold is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rejected_i |-> out_busy_res_i)
    else $error("rejected result reports idle");

endmodule

bind stepper_full_step_sequencer stp_assertions u_stp_assertions (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .out_busy_res_i(out_ch.busy_res),
  .out_rejected_i(out_ch.rejected)
);

/* tb/sv/stp_checker.sv */
// Watches both channels and the register port of the sequencer, keeps its own
// copy of the motor state and compares every result transfer with the oldest
// expectation.
module stp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  stp_in_if           in_ch,
  stp_out_if          out_ch,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          waiting_o,
  output int          compared_o,
  output int          refusals_o
);

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] steps_to_go;
    logic [19:0] ticks_to_go;
    logic [19:0] hold_reload;
    logic        counting_up;
    logic [3:0]  coil_drive;
    logic [15:0] position;
  } motor_t;

  motor_t            motor;
  logic [15:0]       rev_steps;
  stp_pkg::result_t  expected_results[$];
  int                mismatches = 0;
  int                waiting = 0;
  int                compared = 0;
  int                refusals = 0;

  assign mismatches_o = mismatches;
  assign waiting_o    = waiting;
  assign compared_o   = compared;
  assign refusals_o   = refusals;

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("MISMATCH on result %0d: %s", compared, what);
    end
    mismatches++;
  endtask

  // One full step: move the phase, drive its pattern, advance the position.
  function automatic motor_t take_one_step(input motor_t m, input logic [15:0] rev);
    logic [16:0] next_pos;
    m.phase = m.counting_up ? m.phase + 2'd1 : m.phase - 2'd1;
    case (m.phase)
      2'd0:    m.coil_drive = 4'h5;
      2'd1:    m.coil_drive = 4'h6;
      2'd2:    m.coil_drive = 4'hA;
      default: m.coil_drive = 4'h9;
    endcase
    next_pos = {1'b0, m.position} + 17'd1;
    if (rev == 16'd0) begin
      // A zero modulus lets the position run over the whole 16-bit range.
      if (next_pos[16]) begin
        next_pos = '0;
      end
    end else if (next_pos >= {1'b0, rev}) begin
      next_pos = '0;
    end
    m.position = next_pos[15:0];
    return m;
  endfunction

  function automatic stp_pkg::result_t apply_item(input stp_pkg::func_e kind,
                                                  input logic [15:0] count,
                                                  input logic [19:0] hold);
    stp_pkg::result_t r;
    logic             was_busy;
    was_busy   = (motor.steps_to_go != '0) || (motor.ticks_to_go != '0);
    r.rejected = 1'b0;
    case (kind)
      stp_pkg::FUNC_TICK: begin
        if (motor.ticks_to_go != '0) begin
          motor.ticks_to_go = motor.ticks_to_go - 20'd1;
        end
        if (motor.ticks_to_go == '0 && motor.steps_to_go != '0) begin
          motor             = take_one_step(motor, rev_steps);
          motor.steps_to_go = motor.steps_to_go - 16'd1;
          motor.ticks_to_go = motor.hold_reload;
        end
      end
      default: begin
        if (was_busy) begin
          r.rejected = 1'b1;
        end else if (kind == stp_pkg::FUNC_COAST) begin
          motor.coil_drive  = stp_pkg::CoilsOff;
          motor.steps_to_go = '0;
          motor.ticks_to_go = hold;
        end else if (count != '0) begin
          motor.counting_up = (kind == stp_pkg::FUNC_UP);
          motor.hold_reload = hold;
          motor             = take_one_step(motor, rev_steps);
          motor.steps_to_go = count - 16'd1;
          motor.ticks_to_go = hold;
        end
      end
    endcase
    r.coils    = motor.coil_drive;
    r.busy_res = (motor.steps_to_go != '0) || (motor.ticks_to_go != '0);
    r.position = motor.position;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stp_pkg::result_t want;
    if (!rst_ni) begin
      motor     = '0;
      rev_steps = stp_pkg::SprReset;
      expected_results.delete();
      waiting = 0;
    end else begin
      // The result leaving now belongs to an earlier transfer, so it is
      // matched before the item taken at this same edge is predicted.
      if (out_ch.valid && out_ch.ready) begin
        compared++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no expectation waiting");
        end else begin
          want = expected_results.pop_front();
          if (want.rejected) begin
            refusals++;
          end
          if (out_ch.coils !== want.coils) begin
            report_mismatch($sformatf("coils %h, expected %h", out_ch.coils, want.coils));
          end
          if (out_ch.busy_res !== want.busy_res) begin
            report_mismatch($sformatf("busy %b, expected %b",
                                      out_ch.busy_res, want.busy_res));
          end
          if (out_ch.position !== want.position) begin
            report_mismatch($sformatf("position %0d, expected %0d",
                                      out_ch.position, want.position));
          end
          if (out_ch.rejected !== want.rejected) begin
            report_mismatch($sformatf("rejected %b, expected %b",
                                      out_ch.rejected, want.rejected));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_item(stp_pkg::func_e'(in_ch.func),
                                              in_ch.step_count, in_ch.hold_ticks));
      end
      if (cfg_we_i) begin
        rev_steps = cfg_wdata_i;
      end
      waiting = expected_results.size();
    end
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the sequencer testbench. It makes the clock and the single reset,
// drives item transfers and register writes, and plays the result receiver.
// Result checking lives in stp_checker; this module reads its counters, runs a
// watchdog and gives the verdict at the end.
module testbench;

  // Watchdog limit. A correct run stays far below this even with heavy idling and
  // the long receiver hold-off.
  localparam int CycleLimit    = 100_000;
  // Length of the long receiver hold-off used to fill the block up.
  localparam int HoldOffCycles = 60;
  // Random items per random phase.
  localparam int PhaseItems    = 90;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  // Idling mix of the current phase, in percent of cycles.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Set by the hold-off process while the receiver is kept off on purpose.
  logic receiver_held = 1'b0;
  event hold_off_ev;

  // Ticks the block still needs before it takes a command again, as far as
  // the stimulus side can tell. It only shapes the stimulus: the checker has
  // the real prediction.
  int busy_ticks = 0;
  int items_sent = 0;
  int settings_used = 1;
  int cycles = 0;

  int mismatches;
  int waiting;
  int compared;
  int refusals;

  stp_in_if  in_ch ();
  stp_out_if out_ch ();

  stepper_full_step_sequencer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  stp_checker watcher (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mismatches_o (mismatches),
    .waiting_o    (waiting),
    .compared_o   (compared),
    .refusals_o   (refusals)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog: a hung handshake must not run forever.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result receiver. Ready changes only at the falling edge. It stalls at the
  // rate of the current phase and stays low for the whole hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= !receiver_held && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long hold-off, counted in its own process. The flag moves at rising edges
  // so that the receiver reads it cleanly at the falling edge.
  initial begin
    forever begin
      @(hold_off_ev);
      @(posedge clk_i);
      receiver_held = 1'b1;
      repeat (HoldOffCycles) @(posedge clk_i);
      receiver_held = 1'b0;
    end
  end

  // Offers one item and returns at the rising edge where its transfer happens.
  // Idle cycles before the item carry random payload with valid low, which
  // the block has to ignore. Valid is only lowered inside the idle loop, so it
  // never drops and rises again within one time step.
  task automatic send_item(input stp_pkg::func_e kind, input logic [15:0] count,
                           input logic [19:0] hold);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.func       <= stp_pkg::func_e'($urandom_range(3));
      in_ch.step_count <= 16'($urandom);
      in_ch.hold_ticks <= 20'($urandom);
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= kind;
    in_ch.step_count <= count;
    in_ch.hold_ticks <= hold;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    // Track how long the motion lasts: a hold of zero steps on every tick,
    // otherwise each step and the final pattern wait out the whole hold.
    if (kind == stp_pkg::FUNC_TICK) begin
      if (busy_ticks > 0) begin
        busy_ticks--;
      end
    end else if (busy_ticks == 0) begin
      if (kind == stp_pkg::FUNC_COAST) begin
        busy_ticks = int'(hold);
      end else if (count == '0) begin
        busy_ticks = 0;
      end else if (hold == '0) begin
        busy_ticks = int'(count) - 1;
      end else begin
        busy_ticks = int'(count) * int'(hold);
      end
    end
  endtask

  // Ticks until the current motion or coast is over. The payload of a tick is
  // ignored, so it is random over the full field widths.
  task automatic finish_motion();
    while (busy_ticks > 0) begin
      send_item(stp_pkg::FUNC_TICK, 16'($urandom), 20'($urandom));
    end
  endtask

  // Stops offering, waits for every expected result, then lets the result
  // register settle before the register may be written.
  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_rev_steps(input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // One well-formed command with random content, followed by about as many
  // ticks as it needs. Some sequences are cut short so that the next command
  // lands while the block is still busy and gets refused. While the block is
  // known to be busy, stray commands carry full-range fields: they must be
  // refused and change nothing.
  task automatic random_sequence();
    stp_pkg::func_e kind;
    logic [15:0]    count;
    logic [19:0]    hold;
    int             ticks;
    kind  = stp_pkg::func_e'($urandom_range(1, 3));
    count = ($urandom_range(9) == 0) ? 16'd0 :
            16'($urandom_range(1, ($urandom_range(4) == 0) ? 40 : 6));
    hold  = 20'($urandom_range(3));
    send_item(kind, count, hold);
    ticks = busy_ticks + $urandom_range(2);
    if ($urandom_range(99) < 15) begin
      ticks = $urandom_range(busy_ticks);
    end
    repeat (ticks) begin
      if ($urandom_range(99) < 12) begin
        if (busy_ticks > 0) begin
          send_item(stp_pkg::func_e'($urandom_range(1, 3)), 16'($urandom),
                    20'($urandom));
        end else begin
          send_item(stp_pkg::func_e'($urandom_range(1, 3)), 16'($urandom_range(4)),
                    20'($urandom_range(2)));
        end
      end else begin
        send_item(stp_pkg::FUNC_TICK, 16'($urandom), 20'($urandom));
      end
    end
  endtask

  task automatic random_phase(input logic [15:0] rev, input int idle_pct,
                              input int stall_pct);
    int target;
    wait_idle();
    write_rev_steps(rev);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + PhaseItems;
    while (items_sent < target) begin
      random_sequence();
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.func       = stp_pkg::FUNC_TICK;
    in_ch.step_count = '0;
    in_ch.hold_ticks = '0;

    // Reset is held at the start and released at a falling edge.
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset modulus, no idling on either side.
    // A tick with nothing to do, with every payload bit set.
    send_item(stp_pkg::FUNC_TICK, 16'hFFFF, 20'hFFFFF);
    // A move of zero steps is taken but does nothing.
    send_item(stp_pkg::FUNC_UP, 16'd0, 20'd5);
    // Hold of zero: the first step at once, then one step per tick.
    send_item(stp_pkg::FUNC_UP, 16'd3, 20'd0);
    finish_motion();
    // Phase counting down, with a command refused while busy that carries
    // the largest field values.
    send_item(stp_pkg::FUNC_DOWN, 16'd2, 20'd2);
    send_item(stp_pkg::FUNC_UP, 16'hFFFF, 20'hFFFFF);
    finish_motion();
    // Coast switches the coils off and keeps the block busy for its hold.
    send_item(stp_pkg::FUNC_COAST, 16'd9, 20'd2);
    send_item(stp_pkg::FUNC_COAST, 16'd0, 20'd0);
    send_item(stp_pkg::FUNC_DOWN, 16'd1, 20'd0);
    finish_motion();
    // Coast with no hold: coils off and idle at once.
    send_item(stp_pkg::FUNC_COAST, 16'hFFFF, 20'd0);
    // A single step, after which the last pattern stays driven.
    send_item(stp_pkg::FUNC_DOWN, 16'd1, 20'd0);
    send_item(stp_pkg::FUNC_UP, 16'd1, 20'd3);
    finish_motion();

    // Shrink the modulus below the position reached so far: the next step
    // has to wrap at once.
    wait_idle();
    write_rev_steps(16'd2);
    send_item(stp_pkg::FUNC_UP, 16'd3, 20'd1);
    finish_motion();

    // A modulus of zero leaves the position free over the full 16-bit range,
    // so a few steps must count up without wrapping.
    wait_idle();
    write_rev_steps(16'd0);
    send_item(stp_pkg::FUNC_DOWN, 16'd5, 20'd0);
    finish_motion();

    // Largest modulus, again a short run that stays below the wrap.
    wait_idle();
    write_rev_steps(16'hFFFF);
    send_item(stp_pkg::FUNC_UP, 16'd5, 20'd0);
    finish_motion();

    // Random phases with the idling mixes and several moduli, the smallest
    // legal one among them.
    random_phase(16'd1, 64, 0);
    random_phase(16'd13, 0, 64);
    random_phase(16'($urandom_range(1, 65535)), 33, 33);
    random_phase(16'd5, 0, 0);

    // Back pressure: the receiver holds off for a long stretch while items
    // keep coming, so the result register fills and the input stalls.
    wait_idle();
    write_rev_steps(16'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_off_ev;
    repeat (3) random_sequence();

    wait_idle();
    $display("Sent %0d item transfers over %0d register settings and four idling mixes;",
             items_sent, settings_used);
    $display("compared %0d results, %0d of them commands refused while busy.",
             compared, refusals);
    if (mismatches == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
